// ===== sv/lfc_pkg.sv =====
// Shared types and constants of the LRU face cache.
`default_nettype none
package lfc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_PURGE   = 1'b1;

    // Input payload as it sits on the slave tdata bus, first member in the highest bits.
    typedef struct packed {
        logic [6:0]  pad;
        logic        create_failed;
        logic [15:0] pixel_size;
        logic [31:0] key_size;
        logic [47:0] key_addr;
    } t_in_data;

    typedef struct packed {
        logic     req_type;
        t_in_data data;
    } t_req;

    // Result payload as it sits on the master tdata bus.
    typedef struct packed {
        logic [1:0] pad;
        logic [3:0] occupancy;
        logic [2:0] evicted_slot;
        logic       evicted;
        logic       size_change;
        logic       ok;
        logic [2:0] slot;
        logic       hit;
    } t_out_data;

endpackage
`default_nettype wire

// ===== sv/lru_face_cache_top.sv =====
// Top level of the LRU face cache: input register, cache core and result register.
//
// The slave stream carries one request per transaction: tuser selects acquire or
// purge, tdata holds the key (address and length), the pixel size and the flag
// that tells the cache the host could not create a new entry. The master stream
// returns exactly one result per request, in request order.
// A request is captured in the input register, then looked up and applied to
// the cache state once the output register is free, and its result is loaded
// into the output register at that same edge. Throughput is one request per
// cycle while the receiver does not stall; the lookup compares all entries at
// once and the rank update is applied at the same edge as the lookup.
// While the receiver stalls, the result is held and the input register still
// fills, after which s_axis_tready falls until the result is taken.
// Reset empties the cache (all entries invalid, occupancy zero) and empties both
// registers; no clearing pass is needed before the first request.
`default_nettype none
module lru_face_cache_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // key_addr[47:0], key_size[79:48], pixel_size[95:80], create_failed[96], zeros
    input  wire logic [103:0]  s_axis_tdata,
    // req_type[0]
    input  wire logic [0:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // hit[0], slot[3:1], ok[4], size_change[5], evicted[6], evicted_slot[9:7],
    // occupancy[13:10], zeros
    output logic [15:0]        m_axis_tdata
);

    logic                r_in_valid;
    lfc_pkg::t_req       r_in_req;
    logic                r_out_valid;
    lfc_pkg::t_out_data  r_out_res;
    lfc_pkg::t_out_data  core_res;
    logic                fire;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    lfc_lru_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in_req),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req.req_type <= s_axis_tuser[0];
            r_in_req.data     <= lfc_pkg::t_in_data'(s_axis_tdata);
        end
        if (fire) begin
            r_out_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out_res);

endmodule
`default_nettype wire

// ===== sv/lfc_lru_core.sv =====
// Tag store, parallel lookup and recency-rank update of the LRU face cache.
`default_nettype none
module lfc_lru_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire lfc_pkg::t_req     i_req,
    output lfc_pkg::t_out_data     o_res
);

    logic [lfc_pkg::ENTRIES-1:0]   r_valid;
    logic [lfc_pkg::OCC_W-1:0]     r_occ;
    logic [47:0]                   r_addr [lfc_pkg::ENTRIES];
    logic [31:0]                   r_len  [lfc_pkg::ENTRIES];
    logic [15:0]                   r_pix  [lfc_pkg::ENTRIES];
    logic [lfc_pkg::IDX_W-1:0]     r_rank [lfc_pkg::ENTRIES];

    logic [lfc_pkg::ENTRIES-1:0]   match;
    logic [lfc_pkg::ENTRIES-1:0]   pix_ne;
    logic [lfc_pkg::ENTRIES-1:0]   ev_vec;
    logic [lfc_pkg::ENTRIES-1:0]   valid_ev;
    logic [lfc_pkg::ENTRIES-1:0]   ins_vec;
    logic [lfc_pkg::ENTRIES-1:0]   n_valid;
    logic [lfc_pkg::IDX_W-1:0]     n_rank [lfc_pkg::ENTRIES];
    logic [lfc_pkg::OCC_W-1:0]     n_occ;
    logic [lfc_pkg::IDX_W-1:0]     hit_idx;
    logic [lfc_pkg::IDX_W-1:0]     hit_rank;
    logic [lfc_pkg::IDX_W-1:0]     ev_idx;
    logic [lfc_pkg::IDX_W-1:0]     free_idx;
    logic                          acquire;
    logic                          hit;
    logic                          full;
    logic                          ev_found;
    logic                          free_found;
    logic                          ins;

    assign acquire = (i_req.req_type == lfc_pkg::REQ_ACQUIRE);
    assign full    = (r_occ == lfc_pkg::OCC_W'(lfc_pkg::ENTRIES));

    always_comb begin
        hit_idx  = '0;
        hit_rank = '0;
        for (int i = 0; i < lfc_pkg::ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_addr[i] == i_req.data.key_addr)
                        && (r_len[i] == i_req.data.key_size);
            pix_ne[i] = (r_pix[i] != i_req.data.pixel_size);
            if (match[i]) begin
                hit_idx = lfc_pkg::IDX_W'(i);
            end
            hit_rank = hit_rank | (match[i] ? r_rank[i] : '0);
        end
        hit = acquire && (|match);
    end

    // A miss on a full cache drops the entry holding the oldest rank.
    always_comb begin
        ev_vec   = '0;
        ev_idx   = '0;
        ev_found = 1'b0;
        for (int i = 0; i < lfc_pkg::ENTRIES; i++) begin
            if (!ev_found && acquire && !hit && full && r_valid[i]
                    && (r_rank[i] == lfc_pkg::IDX_W'(lfc_pkg::ENTRIES - 1))) begin
                ev_found  = 1'b1;
                ev_vec[i] = 1'b1;
                ev_idx    = lfc_pkg::IDX_W'(i);
            end
        end
        valid_ev = r_valid & ~ev_vec;
    end

    always_comb begin
        ins_vec    = '0;
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = 0; i < lfc_pkg::ENTRIES; i++) begin
            if (!free_found && !valid_ev[i]) begin
                free_found = 1'b1;
                free_idx   = lfc_pkg::IDX_W'(i);
                ins_vec[i] = 1'b1;
            end
        end
        ins = acquire && !hit && !i_req.data.create_failed && free_found;
    end

    always_comb begin
        for (int i = 0; i < lfc_pkg::ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (hit) begin
                if (match[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                    n_rank[i] = r_rank[i] + lfc_pkg::IDX_W'(1);
                end
            end else if (ins) begin
                if (ins_vec[i]) begin
                    n_rank[i] = '0;
                end else if (valid_ev[i]) begin
                    n_rank[i] = r_rank[i] + lfc_pkg::IDX_W'(1);
                end
            end
        end

        if (!acquire) begin
            n_valid = '0;
            n_occ   = '0;
        end else if (hit) begin
            n_valid = r_valid;
            n_occ   = r_occ;
        end else begin
            n_valid = valid_ev | (ins ? ins_vec : '0);
            n_occ   = lfc_pkg::OCC_W'(r_occ - lfc_pkg::OCC_W'(ev_found)
                                      + lfc_pkg::OCC_W'(ins));
        end
    end

    always_comb begin
        o_res              = '0;
        o_res.hit          = hit;
        o_res.ok           = hit || ins;
        o_res.slot         = hit ? 3'(hit_idx) : (ins ? 3'(free_idx) : 3'd0);
        o_res.size_change  = hit ? (|(match & pix_ne)) : ins;
        o_res.evicted      = ev_found;
        o_res.evicted_slot = 3'(ev_idx);
        o_res.occupancy    = 4'(n_occ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else if (i_fire) begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            for (int i = 0; i < lfc_pkg::ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
                if (ins && ins_vec[i]) begin
                    r_addr[i] <= i_req.data.key_addr;
                    r_len[i]  <= i_req.data.key_size;
                    r_pix[i]  <= i_req.data.pixel_size;
                end else if (hit && match[i]) begin
                    r_pix[i]  <= i_req.data.pixel_size;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/lfc_checker.sv =====
// Port-level checks of the LRU face cache, bound to the top level.
`default_nettype none
module lfc_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    input  wire logic [15:0]   m_axis_tdata
);

    lfc_pkg::t_out_data res;
    assign res = lfc_pkg::t_out_data'(m_axis_tdata);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.hit |-> res.ok && !res.evicted && res.evicted_slot == 3'd0)
        else $error("hit result reports an eviction or no entry");

    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.ok |-> res.slot == 3'd0 && !res.size_change && !res.hit)
        else $error("result without an entry carries a slot or size change");

    // An eviction only happens on a full cache, which then refills unless creation failed.
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.evicted |->
            (res.ok && res.occupancy == 4'(lfc_pkg::ENTRIES))
            || (!res.ok && res.occupancy == 4'(lfc_pkg::ENTRIES - 1)))
        else $error("eviction reported with wrong occupancy");

endmodule

bind lru_face_cache_top lfc_checker u_lfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== verif/lfc_result_checker.sv =====
// Checker for the LRU face cache: watches both streams, predicts every result and compares it.
module lfc_result_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_req_valid,
    input  wire logic         i_req_ready,
    // key_addr[47:0], key_size[79:48], pixel_size[95:80], create_failed[96], zeros
    input  wire logic [103:0] i_req_data,
    // req_type[0]
    input  wire logic [0:0]   i_req_user,
    input  wire logic         i_res_valid,
    input  wire logic         i_res_ready,
    // hit[0], slot[3:1], ok[4], size_change[5], evicted[6], evicted_slot[9:7],
    // occupancy[13:10], zeros
    input  wire logic [15:0]  i_res_data,
    output int                o_pending,
    output int                o_fail_count
);

    logic        line_valid [lfc_pkg::ENTRIES];
    logic [47:0] line_addr  [lfc_pkg::ENTRIES];
    logic [31:0] line_len   [lfc_pkg::ENTRIES];
    logic [15:0] line_pix   [lfc_pkg::ENTRIES];
    int          line_rank  [lfc_pkg::ENTRIES];

    lfc_pkg::t_out_data expected_results[$];
    int                 mismatches = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        foreach (line_valid[i]) begin
            line_valid[i] = 1'b0;
            line_rank[i]  = 0;
        end
    end

    function automatic int occupied_lines();
        int n;
        n = 0;
        foreach (line_valid[i])
            if (line_valid[i])
                n++;
        return n;
    endfunction

    // Applies one request to the shadow cache and returns the result it should produce.
    function automatic lfc_pkg::t_out_data apply_request(logic req, lfc_pkg::t_in_data d);
        lfc_pkg::t_out_data res;
        int                 found;
        int                 occ;
        int                 free_idx;
        int                 r;
        res   = '0;
        found = -1;
        if (req == lfc_pkg::REQ_PURGE) begin
            foreach (line_valid[i])
                line_valid[i] = 1'b0;
        end else begin
            foreach (line_valid[i])
                if (line_valid[i] && line_addr[i] == d.key_addr && line_len[i] == d.key_size)
                    found = i;
            if (found >= 0) begin
                r = line_rank[found];
                foreach (line_valid[i])
                    if (line_valid[i] && line_rank[i] < r)
                        line_rank[i]++;
                line_rank[found] = 0;
                res.hit  = 1'b1;
                res.ok   = 1'b1;
                res.slot = 3'(found);
                if (line_pix[found] != d.pixel_size) begin
                    res.size_change = 1'b1;
                    line_pix[found] = d.pixel_size;
                end
            end else begin
                occ = occupied_lines();
                if (occ >= lfc_pkg::ENTRIES) begin
                    for (int i = 0; i < lfc_pkg::ENTRIES; i++) begin
                        if (line_valid[i] && line_rank[i] == occ - 1) begin
                            line_valid[i]    = 1'b0;
                            res.evicted      = 1'b1;
                            res.evicted_slot = 3'(i);
                            break;
                        end
                    end
                end
                // A failed creation leaves any eviction in place but inserts nothing.
                if (!d.create_failed) begin
                    free_idx = -1;
                    for (int i = 0; i < lfc_pkg::ENTRIES; i++) begin
                        if (!line_valid[i]) begin
                            free_idx = i;
                            break;
                        end
                    end
                    if (free_idx >= 0) begin
                        foreach (line_valid[i])
                            if (line_valid[i])
                                line_rank[i]++;
                        line_valid[free_idx] = 1'b1;
                        line_addr[free_idx]  = d.key_addr;
                        line_len[free_idx]   = d.key_size;
                        line_pix[free_idx]   = d.pixel_size;
                        line_rank[free_idx]  = 0;
                        res.slot             = 3'(free_idx);
                        res.ok               = 1'b1;
                        res.size_change      = 1'b1;
                    end
                end
            end
        end
        res.occupancy = 4'(occupied_lines());
        return res;
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val,
                     act_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        lfc_pkg::t_out_data got;
        lfc_pkg::t_out_data want;
        if (!i_rst_n) begin
            expected_results.delete();
            foreach (line_valid[i])
                line_valid[i] = 1'b0;
        end else begin
            // Results are compared before the new request is predicted, so a result can
            // never be matched against the transaction accepted at the same edge.
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", want.hit, got.hit);
                    check_field("slot", want.slot, got.slot);
                    check_field("ok", want.ok, got.ok);
                    check_field("size_change", want.size_change, got.size_change);
                    check_field("evicted", want.evicted, got.evicted);
                    check_field("evicted_slot", want.evicted_slot, got.evicted_slot);
                    check_field("occupancy", want.occupancy, got.occupancy);
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.insert(expected_results.size(),
                                        apply_request(i_req_user[0], i_req_data));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== verif/lru_face_cache_top_test.sv =====
// Testbench top for the LRU face cache: clock, reset, request stimulus, result stalls and verdict.
module lru_face_cache_top_test;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TAIL_CYCLES  = 10;

    typedef struct packed {
        logic [47:0] addr;
        logic [31:0] len;
    } t_face_key;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [15:0]  m_axis_tdata;

    int           pending;
    int           fail_count;
    logic         calm = 1'b0;

    t_face_key    pool [16];
    int           pool_n;
    t_face_key    dk [8];
    logic [15:0]  pix_choices [4] = '{16'd12, 16'd16, 16'd24, 16'hFFFF};

    lru_face_cache_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lfc_result_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, sometimes a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_face_key random_key();
        t_face_key k;
        k.addr = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
        k.len  = 32'($urandom);
        return k;
    endfunction

    function automatic logic [15:0] random_pix();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 16'hFFFF));
        return pix_choices[$urandom_range(0, 3)];
    endfunction

    task automatic send_request(input logic req, input lfc_pkg::t_in_data d);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic acquire(input t_face_key k, input logic [15:0] pix, input logic fail);
        lfc_pkg::t_in_data d;
        d               = '0;
        d.key_addr      = k.addr;
        d.key_size      = k.len;
        d.pixel_size    = pix;
        d.create_failed = fail;
        send_request(lfc_pkg::REQ_ACQUIRE, d);
    endtask

    // The payload of a purge is ignored by the cache, so it is filled with noise.
    task automatic purge();
        lfc_pkg::t_in_data d;
        t_face_key         k;
        k               = random_key();
        d               = '0;
        d.key_addr      = k.addr;
        d.key_size      = k.len;
        d.pixel_size    = random_pix();
        d.create_failed = 1'($urandom_range(0, 1));
        send_request(lfc_pkg::REQ_PURGE, d);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Result side: random stalls, none while the run is in a calm stretch.
    initial begin
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever begin
            gap = calm ? 0 : pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: key extremes, hits with and without a size change,
        // failed creation, filling up, eviction and purges.
        dk[0] = '{48'h0, 32'h0};
        dk[1] = '{48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF};
        dk[2] = '{48'hFFFF_FFFF_FFFF, 32'h0};
        dk[3] = '{48'h0, 32'hFFFF_FFFF};
        for (int i = 4; i < 8; i++)
            dk[i] = random_key();
        acquire(dk[0], 16'h0000, 1'b0);
        acquire(dk[0], 16'h0000, 1'b0);
        acquire(dk[0], 16'hFFFF, 1'b0);
        acquire(dk[1], 16'hFFFF, 1'b1);
        acquire(dk[1], 16'h0001, 1'b0);
        for (int i = 2; i < 8; i++)
            acquire(dk[i], random_pix(), 1'b0);
        acquire(dk[0], 16'hFFFF, 1'b0);
        acquire(random_key(), 16'h0040, 1'b0);
        acquire(random_key(), 16'h0040, 1'b1);
        acquire(dk[2], 16'h0020, 1'b1);
        acquire(dk[3], 16'h1234, 1'b1);
        purge();
        acquire(dk[0], 16'h0010, 1'b0);
        purge();
        purge();
        drain();

        // Random part: a changing pool of keys so hits, promotions and evictions
        // all happen, with some stray keys, failed creations and purges mixed in.
        pool_n = 6;
        for (int i = 0; i < 16; i++)
            pool[i] = random_key();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 250 == 0) begin
                calm   = ($urandom_range(0, 3) == 0);
                pool_n = $urandom_range(3, 14);
                for (int i = 0; i < pool_n; i++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        pool[i] = random_key();
                        if ($urandom_range(0, 3) == 0)
                            pool[i].addr = pool[0].addr;
                    end
                end
            end
            if (n % 400 == 200)
                drain();
            r = $urandom_range(0, 99);
            if (r < 2)
                purge();
            else if (r < 8)
                acquire(random_key(), random_pix(), 1'($urandom_range(0, 1)));
            else
                acquire(pool[$urandom_range(0, pool_n - 1)], random_pix(),
                        ($urandom_range(0, 9) == 0));
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
